### rtl/tdt_pkg.sv
// Package for the dual virtual thumbstick mapper.
// Event kinds, register indexes, sequencer states and reset constants.
// No dependencies.
package tdt_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ID_BITS_DEF    = 8;

    localparam int DW_BITS = 13;
    localparam int MD_BITS = 12;
    localparam int OUT_BITS = 16;

    localparam logic [DW_BITS-1:0] DISPLAY_WIDTH_RST = 13'd1920;
    localparam logic [MD_BITS-1:0] MAX_DISTANCE_RST  = 12'd100;

    // register index is paddr[2]
    localparam logic REG_DISPLAY_WIDTH = 1'b0;
    localparam logic REG_MAX_DISTANCE  = 1'b1;

    // quotient bits produced by the shared divider
    localparam int QUO_BITS = 31;
    localparam int ROOT_BITS = 16;
    // Q1.14 scaling: numerators carry 2*2^14
    localparam int SCALE_SH = 15;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_MOVE    = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_SQ,
        S_LOAD,
        S_DIV,
        S_SQRT,
        S_STORE,
        S_DONE
    } t_back_state;

endpackage

### rtl/tdt_front.sv
// Front end: accepts touch events, tracks stick ownership, centers and positions,
// and pushes a snapshot of both sticks into the queue. Depends on tdt_pkg.
module tdt_front #(
    parameter int COORD_BITS = tdt_pkg::COORD_BITS_DEF,
    parameter int ID_BITS    = tdt_pkg::ID_BITS_DEF,
    parameter int SW         = 8 * COORD_BITS + 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_kind,
    input  logic [ID_BITS-1:0]        i_pointer_id,
    input  logic [COORD_BITS-1:0]     i_pos_x,
    input  logic [COORD_BITS-1:0]     i_pos_y,
    input  logic                      i_batch_end,
    input  logic [tdt_pkg::DW_BITS-1:0] i_display_width,
    input  logic                      i_full,
    output logic                      o_push,
    output logic [SW-1:0]             o_snap
);
    import tdt_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int HW = (CW + 1 > DW_BITS) ? CW + 1 : DW_BITS;

    logic          r_any, n_any;
    logic          r_lown, n_lown, r_rown, n_rown;
    logic [ID_BITS-1:0] r_lid, n_lid, r_rid, n_rid;
    logic [2*CW-1:0] r_lc, n_lc, r_lt, n_lt, r_rc, n_rc, r_rt, n_rt;

    logic [2*CW-1:0] pos;
    logic            left_half;
    logic            lmatch, rmatch;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign pos     = {i_pos_x, i_pos_y};
    assign left_half = (HW'(i_pos_x) << 1) < HW'(i_display_width);
    assign lmatch = r_lown && (i_pointer_id == r_lid);
    assign rmatch = r_rown && (i_pointer_id == r_rid);

    always_comb begin
        n_any  = r_any;
        n_lown = r_lown;
        n_rown = r_rown;
        n_lid  = r_lid;
        n_rid  = r_rid;
        n_lc   = r_lc;
        n_lt   = r_lt;
        n_rc   = r_rc;
        n_rt   = r_rt;
        unique case (i_kind)
            KIND_PRESS: begin
                n_any = 1'b1;
                if (left_half && !r_lown) begin
                    n_lown = 1'b1;
                    n_lid  = i_pointer_id;
                    n_lc   = pos;
                    n_lt   = pos;
                end else if (!left_half && !r_rown) begin
                    n_rown = 1'b1;
                    n_rid  = i_pointer_id;
                    n_rc   = pos;
                    n_rt   = pos;
                end
            end
            KIND_MOVE: begin
                if (r_any) begin
                    if (lmatch) n_lt = pos;
                    if (rmatch) n_rt = pos;
                end
            end
            KIND_RELEASE: begin
                n_any = !i_batch_end;
                if (lmatch) begin
                    n_lown = 1'b0;
                    n_lc   = '0;
                    n_lt   = '0;
                end
                if (rmatch) begin
                    n_rown = 1'b0;
                    n_rc   = '0;
                    n_rt   = '0;
                end
            end
            default: begin
            end
        endcase
        // end of batch with nothing held: everything recenters
        if (i_batch_end && !n_any) begin
            n_lc = '0;
            n_lt = '0;
            n_rc = '0;
            n_rt = '0;
        end
    end

    assign o_snap = {n_lc, n_lt, n_rc, n_rt, n_lown, n_rown};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any  <= 1'b0;
            r_lown <= 1'b0;
            r_rown <= 1'b0;
            r_lid  <= '0;
            r_rid  <= '0;
            r_lc   <= '0;
            r_lt   <= '0;
            r_rc   <= '0;
            r_rt   <= '0;
        end else if (o_push) begin
            r_any  <= n_any;
            r_lown <= n_lown;
            r_rown <= n_rown;
            r_lid  <= n_lid;
            r_rid  <= n_rid;
            r_lc   <= n_lc;
            r_lt   <= n_lt;
            r_rc   <= n_rc;
            r_rt   <= n_rt;
        end
    end

endmodule

### rtl/tdt_queue.sv
// Two-entry queue of stick snapshots between front and back end.
// Depends on tdt_pkg only for style consistency of parameters.
module tdt_queue #(
    parameter int W = 8 * tdt_pkg::COORD_BITS_DEF + 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

### rtl/tdt_back.sv
// Back end: turns a stick snapshot into four Q1.14 components, one at a time,
// with a shared restoring divider and a bit-serial square root. Depends on tdt_pkg.
module tdt_back #(
    parameter int COORD_BITS = tdt_pkg::COORD_BITS_DEF,
    parameter int SW         = 8 * COORD_BITS + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tdt_pkg::MD_BITS-1:0] i_max_distance,
    input  logic                        i_empty,
    input  logic [SW-1:0]               i_snap,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tdt_pkg::OUT_BITS-1:0] o_left_x,
    output logic [tdt_pkg::OUT_BITS-1:0] o_left_y,
    output logic [tdt_pkg::OUT_BITS-1:0] o_right_x,
    output logic [tdt_pkg::OUT_BITS-1:0] o_right_y,
    output logic                        o_left_active,
    output logic                        o_right_active
);
    import tdt_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int D2W = 2 * CW + 1;
    localparam int RW  = D2W + 1;
    localparam int NW  = 2 * CW + 30;
    localparam int LW  = (D2W > 2 * MD_BITS) ? D2W : 2 * MD_BITS;
    localparam int NB  = 15;

    t_back_state r_state, n_state;

    logic [SW-1:0]       r_snap;
    logic [1:0]          r_comp;
    logic [CW-1:0]       r_ax, r_ay;
    logic                r_negx, r_negy, r_zero;
    logic [D2W-1:0]      r_d2;
    logic [2*MD_BITS-1:0] r_mdsq;
    logic                r_big;
    logic [D2W-1:0]      r_div;
    logic [RW-1:0]       r_rem;
    logic [QUO_BITS-1:0] r_nlo, r_quo;
    logic [4:0]          r_cnt;
    logic [ROOT_BITS-1:0] r_root;
    logic [3:0]          r_bit;
    logic [OUT_BITS-1:0] r_res [4];
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_lx, r_ly, r_rx, r_ry;
    logic                r_la, r_ra;

    logic                out_load;
    logic                div_last, sqrt_last;

    // stick select
    logic [2*CW-1:0] c_pt, p_pt;
    logic [CW-1:0]   cx, cy, px, py;
    logic [MD_BITS-1:0] md;
    logic [CW-1:0]   a_sel;
    logic            big_cmp;
    logic [2*CW-1:0] a_sq;
    logic [NW-1:0]   num;
    logic [RW-1:0]   rem_sh, rem_sub;
    logic            ge;
    logic [ROOT_BITS-1:0] trial;
    logic [2*ROOT_BITS-1:0] trial_sq;
    logic [ROOT_BITS:0] root_inc;
    logic [NB-1:0]   nval;
    logic            neg_sel;

    assign md = (i_max_distance == '0) ? MD_BITS'(1) : i_max_distance;

    always_comb begin
        if (r_comp[1]) begin
            c_pt = r_snap[2+4*CW-1 -: 2*CW];
            p_pt = r_snap[2+2*CW-1 -: 2*CW];
        end else begin
            c_pt = r_snap[SW-1 -: 2*CW];
            p_pt = r_snap[2+6*CW-1 -: 2*CW];
        end
    end
    assign cx = c_pt[2*CW-1:CW];
    assign cy = c_pt[CW-1:0];
    assign px = p_pt[2*CW-1:CW];
    assign py = p_pt[CW-1:0];

    assign a_sel   = r_comp[0] ? r_ay : r_ax;
    assign neg_sel = r_comp[0] ? r_negy : r_negx;
    assign big_cmp = LW'(r_d2) > LW'(r_mdsq);
    assign a_sq    = a_sel * a_sel;
    // large vector: T^2 = (a*2^15)^2 over d2; otherwise (a*2^15 + md) over 2*md
    assign num = big_cmp ? {a_sq, 30'd0}
                         : ((NW'(a_sel) << SCALE_SH) + NW'(md));

    assign rem_sh  = {r_rem[RW-2:0], r_nlo[QUO_BITS-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign div_last = (r_cnt == 5'(QUO_BITS - 1));

    assign trial     = r_root | (ROOT_BITS'(1) << r_bit);
    assign trial_sq  = trial * trial;
    assign sqrt_last = (r_bit == 4'd0);

    // round: largest n with 2n-1 <= isqrt(T^2/d2)
    assign root_inc = {1'b0, r_root} + (ROOT_BITS + 1)'(1);
    always_comb begin
        if (r_zero)     nval = '0;
        else if (r_big) nval = root_inc[NB:1];
        else            nval = r_quo[NB-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_empty) n_state = S_ABS;
            S_ABS:   n_state = S_SQ;
            S_SQ:    n_state = S_LOAD;
            S_LOAD:  n_state = r_zero ? S_STORE : S_DIV;
            S_DIV:   if (div_last) n_state = r_big ? S_SQRT : S_STORE;
            S_SQRT:  if (sqrt_last) n_state = S_STORE;
            S_STORE: begin
                if (r_comp == 2'd3)      n_state = S_DONE;
                else if (r_comp == 2'd1) n_state = S_ABS;
                else                     n_state = S_LOAD;
            end
            S_DONE:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == S_IDLE) && !i_empty;
        out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_comp      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) r_comp <= 2'd0;
            else if (r_state == S_STORE) r_comp <= r_comp + 2'd1;
            if (out_load)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_snap <= i_snap;
        unique case (r_state)
            S_ABS: begin
                r_zero <= (c_pt == '0);
                r_negx <= px < cx;
                r_negy <= py < cy;
                r_ax   <= (px < cx) ? cx - px : px - cx;
                r_ay   <= (py < cy) ? cy - py : py - cy;
            end
            S_SQ: begin
                r_d2   <= D2W'(r_ax) * D2W'(r_ax) + D2W'(r_ay) * D2W'(r_ay);
                r_mdsq <= md * md;
            end
            S_LOAD: begin
                r_big <= big_cmp;
                r_div <= big_cmp ? r_d2 : D2W'({md, 1'b0});
                r_rem <= RW'(num[NW-1:QUO_BITS]);
                r_nlo <= num[QUO_BITS-1:0];
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem  <= ge ? rem_sub : rem_sh;
                r_quo  <= {r_quo[QUO_BITS-2:0], ge};
                r_nlo  <= {r_nlo[QUO_BITS-2:0], 1'b0};
                r_cnt  <= r_cnt + 5'd1;
                r_root <= '0;
                r_bit  <= 4'(ROOT_BITS - 1);
            end
            S_SQRT: begin
                if ({1'b0, trial_sq} <= (2 * ROOT_BITS + 1)'(r_quo)) r_root <= trial;
                r_bit <= r_bit - 4'd1;
            end
            S_STORE: begin
                r_res[r_comp] <= neg_sel ? (OUT_BITS'(0) - OUT_BITS'(nval))
                                         : OUT_BITS'(nval);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_lx <= r_res[0];
            r_ly <= r_res[1];
            r_rx <= r_res[2];
            r_ry <= r_res[3];
            r_la <= r_snap[1];
            r_ra <= r_snap[0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_x       = r_lx;
    assign o_left_y       = r_ly;
    assign o_right_x      = r_rx;
    assign o_right_y      = r_ry;
    assign o_left_active  = r_la;
    assign o_right_active = r_ra;

endmodule

### rtl/touch_dual_thumbstick_mapper_top.sv
// Top level of the dual virtual thumbstick mapper: APB registers, front end,
// snapshot queue and back end. Depends on tdt_pkg, tdt_front, tdt_queue, tdt_back.
//
// Each touch event is applied to the stick state in the cycle it is accepted and
// yields one result with both stick vectors in Q1.14. The front end takes an event
// every cycle while the two-entry queue has room; the back end then handles one event
// at a time with its shared 31-step divider and 16-step square root (the root only for
// a vector beyond max_distance, neither for a stick centered at the origin), which work
// through the four components one after the other. Registers: display_width at 0x0,
// max_distance at 0x4.
module touch_dual_thumbstick_mapper_top #(
    parameter int COORD_BITS = tdt_pkg::COORD_BITS_DEF,
    parameter int ID_BITS    = tdt_pkg::ID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_kind,
    input  logic [ID_BITS-1:0]    i_pointer_id,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic                  i_batch_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [tdt_pkg::OUT_BITS-1:0] o_left_x,
    output logic [tdt_pkg::OUT_BITS-1:0] o_left_y,
    output logic [tdt_pkg::OUT_BITS-1:0] o_right_x,
    output logic [tdt_pkg::OUT_BITS-1:0] o_right_y,
    output logic                  o_left_active,
    output logic                  o_right_active
);
    import tdt_pkg::*;

    localparam int SW = 8 * COORD_BITS + 2;

    logic [DW_BITS-1:0] r_display_width;
    logic [MD_BITS-1:0] r_max_distance;
    logic               wr_en;
    logic               push, pop, full, empty;
    logic [SW-1:0]      snap_in, snap_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_width <= DISPLAY_WIDTH_RST;
            r_max_distance  <= MAX_DISTANCE_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_DISPLAY_WIDTH: r_display_width <= pwdata[DW_BITS-1:0];
                REG_MAX_DISTANCE:  r_max_distance  <= pwdata[MD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DISPLAY_WIDTH: prdata = 32'(r_display_width);
            REG_MAX_DISTANCE:  prdata = 32'(r_max_distance);
            default:           prdata = '0;
        endcase
    end

    tdt_front #(
        .COORD_BITS(COORD_BITS),
        .ID_BITS   (ID_BITS),
        .SW        (SW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_kind         (i_kind),
        .i_pointer_id   (i_pointer_id),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_batch_end    (i_batch_end),
        .i_display_width(r_display_width),
        .i_full         (full),
        .o_push         (push),
        .o_snap         (snap_in)
    );

    tdt_queue #(
        .W(SW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (snap_in),
        .i_pop  (pop),
        .o_data (snap_out),
        .o_full (full),
        .o_empty(empty)
    );

    tdt_back #(
        .COORD_BITS(COORD_BITS),
        .SW        (SW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_distance(r_max_distance),
        .i_empty       (empty),
        .i_snap        (snap_out),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_x      (o_left_x),
        .o_left_y      (o_left_y),
        .o_right_x     (o_right_x),
        .o_right_y     (o_right_y),
        .o_left_active (o_left_active),
        .o_right_active(o_right_active)
    );

endmodule

### test/touch_dual_thumbstick_mapper_top_tb.sv
// Testbench for touch_dual_thumbstick_mapper_top: directed event table, then random
// touch sequences under several register settings, checked against typed table results or a built-in predictor.
// Depends on tdt_pkg and the RTL of the mapper.
module touch_dual_thumbstick_mapper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tdt_pkg::*;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 250;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int NUM_PHASES = 5;
    localparam int LONG_HOLD = 600;

    typedef struct packed {
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        logic        la;
        logic        ra;
    } deflection_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [11:0] x;
        logic [11:0] y;
        logic        last;
        logic        typed;
        deflection_t res;
    } touch_row_t;

    localparam deflection_t ALL_ZERO = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = '0;
    logic [7:0]  i_pointer_id = '0;
    logic [11:0] i_pos_x = '0, i_pos_y = '0;
    logic        i_batch_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_left_x, o_left_y, o_right_x, o_right_y;
    logic        o_left_active, o_right_active;

    touch_dual_thumbstick_mapper_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [12:0] p_width;
    logic [11:0] p_maxdist;
    logic        p_any, p_lown, p_rown;
    logic [7:0]  p_lid, p_rid;
    logic [11:0] lcx, lcy, ltx, lty, rcx, rcy, rtx, rty;

    deflection_t expected_q[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int cycles = 0;
    int send_idle_pct = 18;
    int recv_idle_pct = 47;
    int hold_left = 0;
    bit hold_done = 0;

    // largest n in [0,16384] with (2n-1)^2 * d2 <= (2a * 2^14)^2
    function automatic longint unsigned unit_scale(longint unsigned a, longint unsigned d2);
        longint unsigned t, lo, hi, mid, k;
        t = (2 * a) << 14;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            k = 2 * mid - 1;
            if (k * k * d2 <= t * t) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [31:0] stick_deflection(logic [11:0] cx, cy, px, py);
        longint dx, dy;
        longint unsigned ax, ay, d2, md, nx, ny;
        logic [15:0] ox, oy;
        if (cx == 0 && cy == 0) return '0;
        dx = longint'(px) - longint'(cx);
        dy = longint'(py) - longint'(cy);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        d2 = ax * ax + ay * ay;
        md = (p_maxdist == 0) ? 1 : p_maxdist;
        if (d2 <= md * md) begin
            nx = (2 * ax * 16384 + md) / (2 * md);
            ny = (2 * ay * 16384 + md) / (2 * md);
        end else begin
            nx = unit_scale(ax, d2);
            ny = unit_scale(ay, d2);
        end
        ox = dx < 0 ? 16'(0 - nx) : 16'(nx);
        oy = dy < 0 ? 16'(0 - ny) : 16'(ny);
        return {ox, oy};
    endfunction

    function automatic deflection_t apply_touch(logic [1:0] kind, logic [7:0] id,
                                                logic [11:0] x, logic [11:0] y, logic last);
        deflection_t r;
        logic left_half;
        left_half = ({x, 1'b0} < {1'b0, p_width});
        case (kind)
            KIND_PRESS: begin
                p_any = 1'b1;
                if (left_half && !p_lown) begin
                    p_lown = 1'b1; p_lid = id;
                    lcx = x; lcy = y; ltx = x; lty = y;
                end else if (!left_half && !p_rown) begin
                    p_rown = 1'b1; p_rid = id;
                    rcx = x; rcy = y; rtx = x; rty = y;
                end
            end
            KIND_MOVE: begin
                if (p_any) begin
                    if (p_lown && id == p_lid) begin ltx = x; lty = y; end
                    if (p_rown && id == p_rid) begin rtx = x; rty = y; end
                end
            end
            KIND_RELEASE: begin
                p_any = !last;
                if (p_lown && id == p_lid) begin
                    p_lown = 1'b0;
                    lcx = 0; lcy = 0; ltx = 0; lty = 0;
                end
                if (p_rown && id == p_rid) begin
                    p_rown = 1'b0;
                    rcx = 0; rcy = 0; rtx = 0; rty = 0;
                end
            end
            default: ;
        endcase
        // end of batch with nothing held clears all geometry, ownership stays
        if (last && !p_any) begin
            lcx = 0; lcy = 0; ltx = 0; lty = 0;
            rcx = 0; rcy = 0; rtx = 0; rty = 0;
        end
        {r.lx, r.ly} = stick_deflection(lcx, lcy, ltx, lty);
        {r.rx, r.ry} = stick_deflection(rcx, rcy, rtx, rty);
        r.la = p_lown;
        r.ra = p_rown;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[touch_dual_thumbstick_mapper_top] ERROR");
            $finish;
        end
    end

    // result side: check, then decide ready for the next cycle
    always @(posedge i_clk) begin
        deflection_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("result with no event pending");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_left_x !== e.lx) begin
                    $error("left_x exp %h got %h", e.lx, o_left_x); errors++;
                end
                if (o_left_y !== e.ly) begin
                    $error("left_y exp %h got %h", e.ly, o_left_y); errors++;
                end
                if (o_right_x !== e.rx) begin
                    $error("right_x exp %h got %h", e.rx, o_right_x); errors++;
                end
                if (o_right_y !== e.ry) begin
                    $error("right_y exp %h got %h", e.ry, o_right_y); errors++;
                end
                if (o_left_active !== e.la) begin
                    $error("left_active exp %b got %b", e.la, o_left_active); errors++;
                end
                if (o_right_active !== e.ra) begin
                    $error("right_active exp %b got %b", e.ra, o_right_active); errors++;
                end
            end
        end
        // one long back-pressure stretch once the random traffic is flowing
        if (!hold_done && results_seen == 300) begin
            hold_done = 1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr[2] == REG_MAX_DISTANCE) p_maxdist = data[11:0];
        else p_width = data[12:0];
    endtask

    task automatic drain();
        wait (expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // present one item; typed results replace the predictor's
    task automatic send_touch(logic [1:0] kind, logic [7:0] id, logic [11:0] x,
                              logic [11:0] y, logic last, bit typed, deflection_t res);
        deflection_t p;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind; i_pointer_id <= id; i_pos_x <= x; i_pos_y <= y; i_batch_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        p = apply_touch(kind, id, x, y, last);
        expected_q.push_back(typed ? res : p);
        items_sent++;
    endtask

    function automatic logic [11:0] near_coord(logic [11:0] c);
        int v;
        v = int'(c) + $urandom_range(4 * p_maxdist + 8) - 2 * p_maxdist - 4;
        return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
    endfunction

    task automatic random_touch();
        logic [1:0] kind;
        logic [7:0] id;
        logic [11:0] x, y;
        int r;
        r = $urandom_range(99);
        kind = (r < 28) ? KIND_PRESS : (r < 75) ? KIND_MOVE : (r < 95) ? KIND_RELEASE
                                                           : KIND_UNKNOWN;
        id = ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom);
        x = 12'($urandom);
        y = 12'($urandom);
        if (kind == KIND_MOVE && $urandom_range(9) < 8) begin
            // mostly drag an owned stick near its center
            if (p_lown && (!p_rown || $urandom_range(1))) begin
                id = p_lid; x = near_coord(lcx); y = near_coord(lcy);
            end else if (p_rown) begin
                id = p_rid; x = near_coord(rcx); y = near_coord(rcy);
            end
        end else if (kind == KIND_RELEASE && $urandom_range(3) != 0) begin
            if (p_lown && $urandom_range(1)) id = p_lid;
            else if (p_rown) id = p_rid;
        end
        send_touch(kind, id, x, y, ($urandom_range(99) < 25), 0, ALL_ZERO);
    endtask

    touch_row_t directed [24] = '{
        '{KIND_MOVE,    8'd5,   12'd0,    12'd0,    1'b0, 1'b1, ALL_ZERO},
        '{KIND_RELEASE, 8'd5,   12'd0,    12'd0,    1'b1, 1'b1, ALL_ZERO},
        '{KIND_PRESS,   8'd1,   12'd100,  12'd100,  1'b0, 1'b1, {64'd0, 1'b1, 1'b0}},
        '{KIND_MOVE,    8'd1,   12'd200,  12'd100,  1'b0, 1'b1,
          {16'h4000, 16'd0, 32'd0, 1'b1, 1'b0}},
        '{KIND_MOVE,    8'd1,   12'd0,    12'd100,  1'b0, 1'b1,
          {16'hC000, 16'd0, 32'd0, 1'b1, 1'b0}},
        '{KIND_PRESS,   8'd2,   12'd1500, 12'd500,  1'b0, 1'b0, ALL_ZERO},
        '{KIND_PRESS,   8'd3,   12'd10,   12'd10,   1'b0, 1'b0, ALL_ZERO},
        '{KIND_MOVE,    8'd2,   12'd4095, 12'd4095, 1'b0, 1'b0, ALL_ZERO},
        '{KIND_MOVE,    8'd2,   12'd1500, 12'd0,    1'b0, 1'b0, ALL_ZERO},
        '{KIND_UNKNOWN, 8'd2,   12'd7,    12'd7,    1'b0, 1'b0, ALL_ZERO},
        '{KIND_RELEASE, 8'd1,   12'd0,    12'd0,    1'b0, 1'b0, ALL_ZERO},
        '{KIND_PRESS,   8'd0,   12'd0,    12'd0,    1'b0, 1'b0, ALL_ZERO},
        '{KIND_MOVE,    8'd0,   12'd4095, 12'd4095, 1'b0, 1'b0, ALL_ZERO},
        '{KIND_RELEASE, 8'd2,   12'd0,    12'd0,    1'b0, 1'b0, ALL_ZERO},
        '{KIND_RELEASE, 8'd0,   12'd0,    12'd0,    1'b1, 1'b1, ALL_ZERO},
        '{KIND_PRESS,   8'd255, 12'd959,  12'd4095, 1'b0, 1'b0, ALL_ZERO},
        '{KIND_PRESS,   8'd255, 12'd960,  12'd1,    1'b0, 1'b0, ALL_ZERO},
        '{KIND_MOVE,    8'd255, 12'd1000, 12'd2000, 1'b0, 1'b0, ALL_ZERO},
        '{KIND_UNKNOWN, 8'd9,   12'd4095, 12'd0,    1'b1, 1'b0, ALL_ZERO},
        '{KIND_RELEASE, 8'd7,   12'd0,    12'd0,    1'b1, 1'b0, ALL_ZERO},
        '{KIND_MOVE,    8'd255, 12'd30,   12'd40,   1'b0, 1'b0, ALL_ZERO},
        '{KIND_PRESS,   8'd9,   12'd3000, 12'd3000, 1'b0, 1'b0, ALL_ZERO},
        '{KIND_MOVE,    8'd255, 12'd50,   12'd60,   1'b0, 1'b0, ALL_ZERO},
        '{KIND_RELEASE, 8'd255, 12'd0,    12'd0,    1'b1, 1'b1, ALL_ZERO}
    };

    // width, max distance per phase; extremes included
    int phase_width [NUM_PHASES] = '{1920, 1, 4096, 640, 4095};
    int phase_dist  [NUM_PHASES] = '{100, 1, 4095, 37, 2048};

    initial begin
        p_width = DISPLAY_WIDTH_RST; p_maxdist = MAX_DISTANCE_RST;
        p_any = 0; p_lown = 0; p_rown = 0; p_lid = 0; p_rid = 0;
        lcx = 0; lcy = 0; ltx = 0; lty = 0; rcx = 0; rcy = 0; rtx = 0; rty = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i])
            send_touch(directed[i].kind, directed[i].id, directed[i].x, directed[i].y,
                       directed[i].last, directed[i].typed, directed[i].res);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 47 : 0;
            recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 18 : 0;
            i_in_valid <= 1'b0;
            drain();
            reg_write({REG_DISPLAY_WIDTH, 2'b00}, 32'(phase_width[ph]));
            reg_write({REG_MAX_DISTANCE, 2'b00}, 32'(phase_dist[ph]));
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // let the pipe run dry once mid-phase
                if (ph == 3 && n == RANDOM_PER_PHASE / 2) begin
                    i_in_valid <= 1'b0;
                    wait (expected_q.size() == 0);
                end
                random_touch();
            end
        end
        i_in_valid <= 1'b0;
        drain();
        $display("Sent %0d touch events over %0d register settings, %0d results checked.",
                 items_sent, NUM_PHASES + 1, results_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("[touch_dual_thumbstick_mapper_top] OK");
        else
            $display("[touch_dual_thumbstick_mapper_top] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/tdt_pkg.sv
rtl/tdt_front.sv
rtl/tdt_queue.sv
rtl/tdt_back.sv
rtl/touch_dual_thumbstick_mapper_top.sv
test/touch_dual_thumbstick_mapper_top_tb.sv
